### src/d8fd_pkg.sv
package d8fd_pkg;

  localparam int CFG_BITS = 9;
  localparam int GRID_MIN = 16;
  localparam logic [CFG_BITS-1:0] GRID_RESET = 9'd64;

  localparam int DIR_BITS = 4;
  localparam int NUM_DIRS = 8;
  localparam logic [DIR_BITS-1:0] DIR_EDGE = 4'd8;
  localparam logic [DIR_BITS-1:0] DIR_PIT = 4'd9;

  localparam int QUEUE_DEPTH = 4;

  // Neighbor order E, NE, N, NW, W, SW, S, SE; N is the later row.
  localparam int STEP_DX [NUM_DIRS] = '{1, 1, 0, -1, -1, -1, 0, 1};
  localparam int STEP_DY [NUM_DIRS] = '{0, 1, 1, 1, 0, -1, -1, -1};

  typedef struct packed {
    logic left_off;
    logic bottom_off;
    logic ext_x;
    logic ext_y;
  } bound_t;

  localparam int BOUND_BITS = $bits(bound_t);

endpackage

### src/d8fd_front.sv
module d8fd_front #(
  parameter int MAX_GRID_SIZE = 256,
  parameter int HEIGHT_BITS = 24
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic [d8fd_pkg::CFG_BITS-1:0]             grid_size,
  input  logic                                      sample_valid,
  output logic                                      sample_ready,
  input  logic signed [HEIGHT_BITS-1:0]             height,
  input  logic                                      frame_start,
  input  logic                                      queue_full,
  output logic                                      push,
  output logic [9*HEIGHT_BITS-1:0]                  window,
  output logic [$clog2(MAX_GRID_SIZE)-1:0]          base_x,
  output logic [$clog2(MAX_GRID_SIZE)-1:0]          base_y,
  output d8fd_pkg::bound_t                          bound
);

  localparam int CW = $clog2(MAX_GRID_SIZE);
  localparam int NW = CW + 1;
  localparam int DEPTH = 3 * MAX_GRID_SIZE;
  localparam int AW = $clog2(DEPTH);
  localparam int HB = HEIGHT_BITS;

  function automatic logic [AW-1:0] slot_addr(input logic [1:0] s, input logic [CW-1:0] col);
    logic [AW-1:0] base;
    unique case (s)
      2'd1: base = AW'(MAX_GRID_SIZE);
      2'd2: base = AW'(2 * MAX_GRID_SIZE);
      default: base = '0;
    endcase
    return base + AW'(col);
  endfunction

  logic [NW-1:0] n_size;
  logic [NW-1:0] n_last;
  logic [CW-1:0] column_count;
  logic [CW-1:0] row_count;
  logic [1:0]    row_slot;
  logic          accept;
  logic          restart;
  logic [CW-1:0] pos_x;
  logic [CW-1:0] pos_y;
  logic [1:0]    slot_cur;
  logic [1:0]    slot_up1;
  logic [1:0]    slot_up2;
  logic          end_col;
  logic          end_row;

  logic [HB-1:0] line_mem [DEPTH];
  logic [HB-1:0] rd_up1;
  logic [HB-1:0] rd_up2;

  logic             s1_valid;
  logic             s1_resolve;
  logic             s1_fire;
  logic [HB-1:0]    s1_height;
  logic [CW-1:0]    s1_x;
  logic [CW-1:0]    s1_y;
  d8fd_pkg::bound_t s1_bound;
  logic [3*HB-1:0]  col_a;
  logic [3*HB-1:0]  col_b;
  logic [3*HB-1:0]  new_col;

  always_comb begin
    if (grid_size < d8fd_pkg::CFG_BITS'(d8fd_pkg::GRID_MIN)) begin
      n_size = NW'(d8fd_pkg::GRID_MIN);
    end else if (32'(grid_size) > 32'(MAX_GRID_SIZE)) begin
      n_size = NW'(MAX_GRID_SIZE);
    end else begin
      n_size = NW'(grid_size);
    end
  end

  assign n_last = n_size - NW'(1);
  assign accept = sample_valid && sample_ready;

  // A sample outside the current grid starts a new grid at the origin.
  always_comb begin
    restart = frame_start || ({1'b0, column_count} >= n_size) || ({1'b0, row_count} >= n_size);
    pos_x = restart ? '0 : column_count;
    pos_y = restart ? '0 : row_count;
    slot_cur = restart ? 2'd0 : row_slot;
  end

  always_comb begin
    unique case (slot_cur)
      2'd0: begin
        slot_up1 = 2'd2;
        slot_up2 = 2'd1;
      end
      2'd1: begin
        slot_up1 = 2'd0;
        slot_up2 = 2'd2;
      end
      2'd2: begin
        slot_up1 = 2'd1;
        slot_up2 = 2'd0;
      end
      default: begin
        slot_up1 = 2'd0;
        slot_up2 = 2'd0;
      end
    endcase
  end

  assign end_col = ({1'b0, pos_x} == n_last);
  assign end_row = ({1'b0, pos_y} == n_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count <= '0;
      row_slot <= 2'd0;
    end else if (accept) begin
      if (end_col) begin
        column_count <= '0;
        if (end_row) begin
          row_count <= '0;
          row_slot <= 2'd0;
        end else begin
          row_count <= pos_y + CW'(1);
          row_slot <= (slot_cur == 2'd2) ? 2'd0 : slot_cur + 2'd1;
        end
      end else begin
        column_count <= pos_x + CW'(1);
        row_count <= pos_y;
        row_slot <= slot_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      line_mem[slot_addr(slot_cur, pos_x)] <= height;
      rd_up1 <= line_mem[slot_addr(slot_up1, pos_x)];
      rd_up2 <= line_mem[slot_addr(slot_up2, pos_x)];
    end
  end

  assign s1_fire = s1_valid && (!s1_resolve || !queue_full);
  assign sample_ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_height <= height;
      s1_x <= pos_x - CW'(1);
      s1_y <= pos_y - CW'(1);
      s1_resolve <= (pos_x != '0) && (pos_y != '0);
      s1_bound.left_off <= (pos_x == CW'(1));
      s1_bound.bottom_off <= (pos_y == CW'(1));
      s1_bound.ext_x <= end_col;
      s1_bound.ext_y <= end_row;
    end
  end

  // Rows within a column run from two rows back up to the current row.
  assign new_col = {s1_height, rd_up1, rd_up2};

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      col_a <= col_b;
      col_b <= new_col;
    end
  end

  assign push = s1_fire && s1_resolve;
  assign window = {new_col, col_b, col_a};
  assign base_x = s1_x;
  assign base_y = s1_y;
  assign bound = s1_bound;

endmodule

### src/d8fd_queue.sv
module d8fd_queue #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             full,
  output logic             head_valid,
  output logic [WIDTH-1:0] head
);

  localparam int PW = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CNTW-1:0]  count;

  assign full = (count == CNTW'(DEPTH));
  assign head_valid = (count != '0);
  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      count <= count + CNTW'(push) - CNTW'(pop);
    end
  end

endmodule

### src/d8fd_back.sv
module d8fd_back #(
  parameter int MAX_GRID_SIZE = 256,
  parameter int HEIGHT_BITS = 24
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 head_valid,
  input  logic [9*HEIGHT_BITS-1:0]             window,
  input  logic [$clog2(MAX_GRID_SIZE)-1:0]     base_x,
  input  logic [$clog2(MAX_GRID_SIZE)-1:0]     base_y,
  input  d8fd_pkg::bound_t                     bound,
  output logic                                 pop,
  output logic                                 result_valid,
  input  logic                                 result_ready,
  output logic [$clog2(MAX_GRID_SIZE)-1:0]     cell_x,
  output logic [$clog2(MAX_GRID_SIZE)-1:0]     cell_y,
  output logic [d8fd_pkg::DIR_BITS-1:0]        direction,
  output logic                                 last,
  output logic                                 grid_done
);

  localparam int CW = $clog2(MAX_GRID_SIZE);
  localparam int HB = HEIGHT_BITS;
  localparam int KW = 2 * HB + 1;
  localparam int DB = d8fd_pkg::DIR_BITS;
  localparam int ND = d8fd_pkg::NUM_DIRS;

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic          last;
    logic          grid_done;
  } meta_t;

  logic          advance;
  logic          take;
  logic          done;
  logic          ox;
  logic          oy;
  logic [HB-1:0] win [3][3];
  logic [1:0]    ci;
  logic [1:0]    cj;
  logic [HB-1:0] hc;

  logic [HB-1:0] drop_next [ND];
  logic [DB-1:0] code_next [ND];
  meta_t         meta_next;

  logic          v1, v2, v3, v4;
  logic [HB-1:0] s1_drop [ND];
  logic [DB-1:0] s1_code [ND];
  meta_t         s1_meta;
  logic [KW-1:0] s2_key [ND];
  logic [DB-1:0] s2_code [ND];
  meta_t         s2_meta;
  logic [KW-1:0] s3_key [ND/2];
  logic [DB-1:0] s3_code [ND/2];
  meta_t         s3_meta;
  logic [KW-1:0] s4_key [ND/4];
  logic [DB-1:0] s4_code [ND/4];
  meta_t         s4_meta;

  logic [KW-1:0] key_next [ND];
  logic [KW-1:0] l1_key [ND/2];
  logic [DB-1:0] l1_code [ND/2];
  logic [KW-1:0] l2_key [ND/4];
  logic [DB-1:0] l2_code [ND/4];
  logic [KW-1:0] best_key;
  logic [DB-1:0] best_code;

  assign advance = !result_valid || result_ready;
  assign take = advance && head_valid;
  assign done = !((!ox && bound.ext_x) || (!oy && bound.ext_y));
  assign pop = take && done;

  // One queued window yields up to four cells: the base cell, then the one
  // to its right and the row above when the grid edge is reached.
  always_ff @(posedge clk) begin
    if (rst) begin
      ox <= 1'b0;
      oy <= 1'b0;
    end else if (take) begin
      if (done) begin
        ox <= 1'b0;
        oy <= 1'b0;
      end else if (!ox && bound.ext_x) begin
        ox <= 1'b1;
      end else begin
        ox <= 1'b0;
        oy <= 1'b1;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        win[i][j] = window[(i*3+j)*HB +: HB];
      end
    end
  end

  assign ci = 2'd1 + {1'b0, ox};
  assign cj = 2'd1 + {1'b0, oy};
  assign hc = win[ci][cj];

  always_comb begin
    int ii;
    int jj;
    logic nb_off;
    logic [HB-1:0] hn;
    logic signed [HB:0] drop;
    ii = 0;
    jj = 0;
    nb_off = 1'b0;
    hn = '0;
    drop = '0;
    for (int k = 0; k < ND; k++) begin
      ii = 1 + int'(ox) + d8fd_pkg::STEP_DX[k];
      jj = 1 + int'(oy) + d8fd_pkg::STEP_DY[k];
      nb_off = (ii == 3) || (jj == 3) || ((ii == 0) && bound.left_off) ||
               ((jj == 0) && bound.bottom_off);
      if (nb_off) begin
        hn = '0;
      end else begin
        hn = win[ii[1:0]][jj[1:0]];
      end
      drop = $signed({hc[HB-1], hc}) - $signed({hn[HB-1], hn});
      drop_next[k] = (!drop[HB] && (drop != '0)) ? drop[HB-1:0] : '0;
      code_next[k] = nb_off ? d8fd_pkg::DIR_EDGE : DB'(k);
    end
  end

  always_comb begin
    meta_next.x = base_x + CW'(ox);
    meta_next.y = base_y + CW'(oy);
    meta_next.last = done;
    meta_next.grid_done = ox && oy;
  end

  // Orthogonal drop d ranks as 2*d*d and diagonal as d*d, which orders
  // d against d/sqrt2 exactly.
  always_comb begin
    logic [2*HB-1:0] prod;
    prod = '0;
    for (int k = 0; k < ND; k++) begin
      prod = s1_drop[k] * s1_drop[k];
      key_next[k] = (k % 2 == 1) ? {1'b0, prod} : {prod, 1'b0};
    end
  end

  // The earlier neighbor keeps ties, so the later one wins only when larger.
  always_comb begin
    for (int p = 0; p < ND / 2; p++) begin
      if (s2_key[2*p+1] > s2_key[2*p]) begin
        l1_key[p] = s2_key[2*p+1];
        l1_code[p] = s2_code[2*p+1];
      end else begin
        l1_key[p] = s2_key[2*p];
        l1_code[p] = s2_code[2*p];
      end
    end
    for (int p = 0; p < ND / 4; p++) begin
      if (s3_key[2*p+1] > s3_key[2*p]) begin
        l2_key[p] = s3_key[2*p+1];
        l2_code[p] = s3_code[2*p+1];
      end else begin
        l2_key[p] = s3_key[2*p];
        l2_code[p] = s3_code[2*p];
      end
    end
    if (s4_key[1] > s4_key[0]) begin
      best_key = s4_key[1];
      best_code = s4_code[1];
    end else begin
      best_key = s4_key[0];
      best_code = s4_code[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      result_valid <= 1'b0;
    end else if (advance) begin
      v1 <= take;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      result_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_drop <= drop_next;
      s1_code <= code_next;
      s1_meta <= meta_next;
      s2_key <= key_next;
      s2_code <= s1_code;
      s2_meta <= s1_meta;
      s3_key <= l1_key;
      s3_code <= l1_code;
      s3_meta <= s2_meta;
      s4_key <= l2_key;
      s4_code <= l2_code;
      s4_meta <= s3_meta;
      cell_x <= s4_meta.x;
      cell_y <= s4_meta.y;
      last <= s4_meta.last;
      grid_done <= s4_meta.grid_done;
      direction <= (best_key == '0) ? d8fd_pkg::DIR_PIT : best_code;
    end
  end

endmodule

### src/d8_flow_direction_raster.sv
// Throughput: one sample per cycle while sample_ready is high; the direction unit
// delivers one result per cycle while result_ready is high, so the extra results at
// the end of a row, and up to four per sample in the last row, take added cycles that
// the four-entry window queue absorbs before sample_ready drops.
// Reset clears the position counters and the pipeline and sets the grid size to 64;
// the line store is not cleared and holds no valid data until rows are written.
module d8_flow_direction_raster #(
  parameter int MAX_GRID_SIZE = 256,
  parameter int HEIGHT_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [d8fd_pkg::CFG_BITS-1:0]     grid_size,
  input  logic                              sample_valid,
  output logic                              sample_ready,
  input  logic signed [HEIGHT_BITS-1:0]     height,
  input  logic                              frame_start,
  output logic                              result_valid,
  input  logic                              result_ready,
  output logic [$clog2(MAX_GRID_SIZE)-1:0]  cell_x,
  output logic [$clog2(MAX_GRID_SIZE)-1:0]  cell_y,
  output logic [d8fd_pkg::DIR_BITS-1:0]     direction,
  output logic                              last,
  output logic                              grid_done
);

  localparam int CW = $clog2(MAX_GRID_SIZE);
  localparam int WINW = 9 * HEIGHT_BITS;
  localparam int QW = WINW + 2 * CW + d8fd_pkg::BOUND_BITS;

  logic [d8fd_pkg::CFG_BITS-1:0] size_cfg;

  logic             push;
  logic             queue_full;
  logic             head_valid;
  logic             pop;
  logic [WINW-1:0]  push_window;
  logic [CW-1:0]    push_x;
  logic [CW-1:0]    push_y;
  d8fd_pkg::bound_t push_bound;
  logic [QW-1:0]    head;
  logic [WINW-1:0]  head_window;
  logic [CW-1:0]    head_x;
  logic [CW-1:0]    head_y;
  d8fd_pkg::bound_t head_bound;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_cfg <= d8fd_pkg::GRID_RESET;
    end else if (cfg_valid && cfg_ready) begin
      size_cfg <= grid_size;
    end
  end

  d8fd_front #(
    .MAX_GRID_SIZE(MAX_GRID_SIZE),
    .HEIGHT_BITS(HEIGHT_BITS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .grid_size(size_cfg),
    .sample_valid(sample_valid),
    .sample_ready(sample_ready),
    .height(height),
    .frame_start(frame_start),
    .queue_full(queue_full),
    .push(push),
    .window(push_window),
    .base_x(push_x),
    .base_y(push_y),
    .bound(push_bound)
  );

  d8fd_queue #(
    .WIDTH(QW),
    .DEPTH(d8fd_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_data({push_window, push_x, push_y, push_bound}),
    .pop(pop),
    .full(queue_full),
    .head_valid(head_valid),
    .head(head)
  );

  assign {head_window, head_x, head_y, head_bound} = head;

  d8fd_back #(
    .MAX_GRID_SIZE(MAX_GRID_SIZE),
    .HEIGHT_BITS(HEIGHT_BITS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .head_valid(head_valid),
    .window(head_window),
    .base_x(head_x),
    .base_y(head_y),
    .bound(head_bound),
    .pop(pop),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .cell_x(cell_x),
    .cell_y(cell_y),
    .direction(direction),
    .last(last),
    .grid_done(grid_done)
  );

endmodule
